// ----- hw/rtl/kht_pkg.sv -----
package kht_pkg;

	localparam int KEY_W    = 48;
	localparam int HANDLE_W = 32;

	// Request codes.
	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_TAKE   = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	// Response codes.
	typedef enum logic [1:0] {
		STS_OK   = 2'd0,
		STS_MISS = 2'd1,
		STS_FULL = 2'd2,
		STS_NULL = 2'd3
	} status_t;

	// One table slot as held in the memory.
	typedef struct packed {
		logic                valid;
		logic [KEY_W-1:0]    key;
		logic [HANDLE_W-1:0] handle;
	} entry_t;

endpackage

// ----- hw/rtl/kht_req_if.sv -----
interface kht_req_if;
	import kht_pkg::*;

	logic                valid;
	logic                ready;
	cmd_t                command;
	logic [KEY_W-1:0]    key;
	logic [HANDLE_W-1:0] handle;

	modport source (output valid, output command, output key, output handle, input ready);
	modport sink   (input valid, input command, input key, input handle, output ready);

endinterface

// ----- hw/rtl/kht_rsp_if.sv -----
interface kht_rsp_if;
	import kht_pkg::*;

	logic                valid;
	logic                ready;
	status_t             status;
	logic [HANDLE_W-1:0] found_handle;

	modport source (output valid, output status, output found_handle, input ready);
	modport sink   (input valid, input status, input found_handle, output ready);

endinterface

// ----- hw/rtl/keyed_handle_table.sv -----
// Fully associative table of ENTRIES slots, each a valid mark, a 48-bit key and a
// 32-bit handle, held in one single-port-write, single-port-read synchronous memory.
// Every request is served alone: insert, search and take read all ENTRIES slots in
// turn, one memory read a cycle, and then write back at most one slot before the
// next request is accepted. A clear request sweeps the memory one slot a cycle; any
// other request with a null key, or an insert with a null handle, skips the scan and
// goes straight to its response. After reset the block sweeps every slot invalid
// and accepts no request until the sweep is done. Results leave through an output
// register, so a new request is taken while a response still waits to be
// transferred. Lookups return the lowest-numbered matching slot.
module keyed_handle_table #(
	parameter int ENTRIES = 64
) (
	input logic      clk,
	input logic      arst_n,
	kht_req_if.sink   req,
	kht_rsp_if.source rsp
);
	import kht_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [5:0] {
		S_INIT   = 6'b000001,
		S_IDLE   = 6'b000010,
		S_SCAN   = 6'b000100,
		S_DRAIN  = 6'b001000,
		S_CLEAR  = 6'b010000,
		S_COMMIT = 6'b100000
	} state_t;

	state_t state_q;

	// Table memory and its ports.
	entry_t           mem [ENTRIES];
	logic             wr_en;
	logic [IDX_W-1:0] wr_idx;
	entry_t           wr_data;
	logic             rd_en;
	entry_t           rd_data_s1;
	logic             rd_vld_s1;

	// Request held for the duration of its work.
	cmd_t                cmd_q;
	logic [KEY_W-1:0]    key_q;
	logic [HANDLE_W-1:0] handle_q;
	logic                null_q;

	// Scan progress and findings.
	logic [IDX_W-1:0]    scan_idx_q;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic [HANDLE_W-1:0] hit_handle_q;
	logic                free_q;
	logic [IDX_W-1:0]    free_idx_q;

	// Output register.
	logic                out_valid_q;
	status_t             status_q;
	logic [HANDLE_W-1:0] found_q;

	logic    req_xfer;
	logic    commit_go;
	status_t commit_status;
	logic [HANDLE_W-1:0] commit_found;

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign commit_go = (state_q == S_COMMIT) && (!out_valid_q || rsp.ready);

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.found_handle = found_q;

	// Memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[scan_idx_q];
		end
	end

	assign rd_en = (state_q == S_SCAN);

	// Decide the outcome of the request and the write-back it needs.
	always_comb begin
		wr_en         = 1'b0;
		wr_idx        = scan_idx_q;
		wr_data       = '0;
		commit_status = STS_OK;
		commit_found  = '0;
		priority if (state_q == S_INIT || state_q == S_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == S_COMMIT) begin
			priority if (cmd_q == CMD_CLEAR) begin
				commit_status = STS_OK;
			end else if (null_q) begin
				commit_status = STS_NULL;
			end else if (cmd_q == CMD_INSERT) begin
				wr_data = '{valid: 1'b1, key: key_q, handle: handle_q};
				priority if (hit_q) begin
					wr_en  = commit_go;
					wr_idx = hit_idx_q;
				end else if (free_q) begin
					wr_en  = commit_go;
					wr_idx = free_idx_q;
				end else begin
					commit_status = STS_FULL;
				end
			end else if (hit_q) begin
				commit_found = hit_handle_q;
				// A take frees the slot that matched.
				wr_en  = commit_go && (cmd_q == CMD_TAKE);
				wr_idx = hit_idx_q;
			end else begin
				commit_status = STS_MISS;
			end
		end else begin
			// Idle, scan and drain leave the memory untouched.
			wr_en = 1'b0;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			scan_idx_q  <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			// A new result fills the output register; a transfer empties it.
			if (commit_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_INIT: begin
					if (scan_idx_q == LAST_IDX) begin
						scan_idx_q <= '0;
						state_q    <= S_IDLE;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				S_IDLE: begin
					if (req_xfer) begin
						scan_idx_q <= '0;
						hit_q      <= 1'b0;
						free_q     <= 1'b0;
						priority if (req.command == CMD_CLEAR) begin
							state_q <= S_CLEAR;
						end else if (req.key == '0 ||
							(req.command == CMD_INSERT && req.handle == '0)) begin
							state_q <= S_COMMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_idx_q == LAST_IDX) begin
						scan_idx_q <= '0;
						state_q    <= S_DRAIN;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_COMMIT;
				end
				S_CLEAR: begin
					if (scan_idx_q == LAST_IDX) begin
						scan_idx_q <= '0;
						state_q    <= S_COMMIT;
					end else begin
						scan_idx_q <= scan_idx_q + IDX_W'(1);
					end
				end
				S_COMMIT: begin
					if (commit_go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase

			// Note the first matching slot and the first free slot as reads return.
			if (rd_vld_s1) begin
				if (rd_data_s1.valid && rd_data_s1.key == key_q && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (!rd_data_s1.valid && !free_q) begin
					free_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN) begin
			rd_idx_s1 <= scan_idx_q;
		end
		if (req_xfer) begin
			cmd_q    <= req.command;
			key_q    <= req.key;
			handle_q <= req.handle;
			null_q   <= (req.key == '0) || (req.command == CMD_INSERT && req.handle == '0);
		end
		if (rd_vld_s1) begin
			if (rd_data_s1.valid && rd_data_s1.key == key_q && !hit_q) begin
				hit_idx_q    <= rd_idx_s1;
				hit_handle_q <= rd_data_s1.handle;
			end
			if (!rd_data_s1.valid && !free_q) begin
				free_idx_q <= rd_idx_s1;
			end
		end
		if (commit_go) begin
			status_q <= commit_status;
			found_q  <= commit_found;
		end
	end

endmodule

// ----- tb/sv/keyed_handle_table_test.sv -----
module keyed_handle_table_test;
	import kht_pkg::*;

	localparam int SLOTS = 64;
	localparam int POOL_KEYS = 96;
	localparam int unsigned CYCLE_LIMIT = 600000;

	// One expected response: the status code and the handle returned with it.
	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] found;
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	kht_req_if req ();
	kht_rsp_if rsp ();

	keyed_handle_table #(.ENTRIES(SLOTS)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// Shadow copy of the table contents.
	logic                slot_used   [SLOTS];
	logic [KEY_W-1:0]    slot_key    [SLOTS];
	logic [HANDLE_W-1:0] slot_handle [SLOTS];

	// Distinct non-zero keys, reused so that lookups hit and the table fills.
	logic [KEY_W-1:0] key_pool [POOL_KEYS];

	answer_t     pending_answers [$];
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned hold_off = 0;
	bit          req_gaps = 1'b1;
	bit          rsp_stalls = 1'b1;

	// Free-running clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic report_mismatch(string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatches++;
	endtask

	// Apply one request to the shadow table and work out the response it must give.
	function automatic answer_t table_answer(cmd_t c, logic [KEY_W-1:0] k,
			logic [HANDLE_W-1:0] h);
		answer_t a;
		int      hit;
		int      spare;
		int      i;
		a.status = STS_OK;
		a.found = '0;
		hit = -1;
		spare = -1;
		// Scan downwards so that the lowest-numbered match and free slot win.
		for (i = SLOTS - 1; i >= 0; i--) begin
			if (slot_used[i] && slot_key[i] == k)
				hit = i;
			if (!slot_used[i])
				spare = i;
		end
		if (c == CMD_CLEAR) begin
			for (i = 0; i < SLOTS; i++)
				slot_used[i] = 1'b0;
		end else if (k == '0) begin
			a.status = STS_NULL;
		end else if (c == CMD_INSERT) begin
			if (h == '0) begin
				a.status = STS_NULL;
			end else begin
				if (hit < 0)
					hit = spare;
				if (hit < 0) begin
					a.status = STS_FULL;
				end else begin
					slot_used[hit] = 1'b1;
					slot_key[hit] = k;
					slot_handle[hit] = h;
				end
			end
		end else if (hit < 0) begin
			a.status = STS_MISS;
		end else begin
			a.found = slot_handle[hit];
			if (c == CMD_TAKE)
				slot_used[hit] = 1'b0;
		end
		return a;
	endfunction

	// Compare one response transfer with the oldest expectation.
	task automatic check_answer(status_t s, logic [HANDLE_W-1:0] f);
		answer_t want;
		if (pending_answers.size() == 0) begin
			report_mismatch($sformatf("response status %0d handle %h with none pending",
				s, f));
		end else begin
			want = pending_answers.pop_front();
			if (s !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", s, want.status));
			if (f !== want.found)
				report_mismatch($sformatf("found_handle %h, expected %h", f, want.found));
		end
	endtask

	// Response side: checks every transfer and stalls at random or for a set stretch.
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready)
				check_answer(rsp.status, rsp.found_handle);
			if (hold_off > 0) begin
				hold_off--;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= !(rsp_stalls && $urandom_range(99) < 24);
			end
		end
	end

	// Offer one request, wait for its transfer and record what it must answer.
	task automatic send_request(cmd_t c, logic [KEY_W-1:0] k, logic [HANDLE_W-1:0] h);
		while (req_gaps && $urandom_range(99) < 24) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.command <= c;
		req.key <= k;
		req.handle <= h;
		do @(posedge clk); while (!req.ready);
		pending_answers.push_back(table_answer(c, k, h));
	endtask

	// Stop offering until every outstanding response has been transferred.
	task automatic wait_for_drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_answers.size() != 0)
			@(posedge clk);
	endtask

	// One random request; keys mostly come from the first pool_n pool entries.
	task automatic send_random(int unsigned pool_n, int unsigned ins_pct);
		cmd_t             c;
		logic [KEY_W-1:0] k;
		logic [HANDLE_W-1:0] h;
		int unsigned      r;
		int unsigned      search_lim;
		search_lim = ins_pct + (98 - ins_pct) / 2;
		r = $urandom_range(99);
		if (r < ins_pct)
			c = CMD_INSERT;
		else if (r < search_lim)
			c = CMD_SEARCH;
		else if (r < 98)
			c = CMD_TAKE;
		else
			c = CMD_CLEAR;
		r = $urandom_range(99);
		if (r < 4)
			k = '0;
		else if (r < 24)
			k = {16'($urandom), 32'($urandom)};
		else
			k = key_pool[$urandom_range(pool_n - 1)];
		h = ($urandom_range(99) < 4) ? '0 : 32'($urandom);
		send_request(c, k, h);
	endtask

	// Null keys and handles, misses, hits, updates, takes and clears at the extremes.
	task automatic test_directed();
		send_request(CMD_INSERT, '0, '1);
		send_request(CMD_SEARCH, '0, '1);
		send_request(CMD_TAKE, '0, '0);
		send_request(CMD_INSERT, '1, '0);
		send_request(CMD_SEARCH, '1, '0);
		send_request(CMD_TAKE, '1, '0);
		send_request(CMD_INSERT, '1, '1);
		send_request(CMD_SEARCH, '1, '0);
		send_request(CMD_INSERT, '1, 32'd1);
		send_request(CMD_SEARCH, '1, '1);
		send_request(CMD_INSERT, 48'd1, 32'd1);
		send_request(CMD_TAKE, 48'd1, '0);
		send_request(CMD_TAKE, 48'd1, '0);
		send_request(CMD_INSERT, 48'h5555_5555_5555, 32'hAAAA_AAAA);
		send_request(CMD_INSERT, 48'hAAAA_AAAA_AAAA, 32'h5555_5555);
		send_request(CMD_SEARCH, 48'h5555_5555_5555, '0);
		send_request(CMD_CLEAR, '1, '1);
		send_request(CMD_SEARCH, '1, '0);
		send_request(CMD_SEARCH, 48'hAAAA_AAAA_AAAA, '0);
		send_request(CMD_CLEAR, '0, '0);
		send_request(CMD_INSERT, 48'd1, '1);
	endtask

	// Fill the table, with the response side holding off at first, then probe the full table.
	task automatic test_fill_and_stall();
		int unsigned i;
		send_request(CMD_CLEAR, {16'($urandom), 32'($urandom)}, 32'($urandom));
		hold_off = 300;
		for (i = 0; i < SLOTS + 6; i++)
			send_request(CMD_INSERT, key_pool[i], 32'($urandom) | 32'd1);
		// An update still succeeds on a full table; a freed slot is refilled.
		send_request(CMD_INSERT, key_pool[5], 32'($urandom) | 32'd1);
		send_request(CMD_TAKE, key_pool[20], '0);
		send_request(CMD_INSERT, key_pool[SLOTS + 2], 32'($urandom) | 32'd1);
		send_request(CMD_SEARCH, key_pool[SLOTS + 2], '0);
		send_request(CMD_SEARCH, key_pool[SLOTS + 3], '0);
		send_request(CMD_INSERT, key_pool[SLOTS + 3], 32'($urandom) | 32'd1);
		wait_for_drain();
	endtask

	// Mixed traffic with random gaps on both sides and a pause now and then.
	task automatic test_random_traffic();
		int unsigned n;
		for (n = 0; n < 250; n++) begin
			send_random(80, 40);
			if (n % 50 == 49)
				wait_for_drain();
		end
		// Insert-heavy traffic keeps the table near full.
		for (n = 0; n < 150; n++) begin
			send_random(70, 60);
			if (n % 50 == 49)
				wait_for_drain();
		end
		// Few keys, so most lookups hit.
		for (n = 0; n < 150; n++)
			send_random(12, 35);
		wait_for_drain();
	endtask

	// A long stretch with neither side idling.
	task automatic test_back_to_back();
		int unsigned n;
		req_gaps = 1'b0;
		rsp_stalls = 1'b0;
		for (n = 0; n < 150; n++)
			send_random(40, 45);
		req_gaps = 1'b1;
		rsp_stalls = 1'b1;
	endtask

	initial begin
		int i;
		req.valid <= 1'b0;
		req.command <= CMD_INSERT;
		req.key <= '0;
		req.handle <= '0;
		for (i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i] = '0;
			slot_handle[i] = '0;
		end
		// The low bits hold the index, so every pool key is distinct and non-zero.
		for (i = 0; i < POOL_KEYS; i++)
			key_pool[i] = {41'({$urandom, $urandom}), 7'(i + 1)};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_fill_and_stall();
		test_random_traffic();
		test_back_to_back();

		// Let the last response arrive and give the block time to show any stray one.
		wait_for_drain();
		repeat (SLOTS + 8) @(posedge clk);
		if (pending_answers.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", pending_answers.size()));
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
